// ----- src/acqf_pkg.sv -----
// acqf_pkg: shared types, constants and helpers for the block header framer.
// No dependencies.
package acqf_pkg;

    localparam int TYPE_W      = 16;
    localparam int CHAN_W      = 16;
    localparam int WORD16_W    = 16;
    localparam int STAMP_HI_W  = 8;
    localparam int STAMP_LO_W  = 32;
    localparam int STAMP_W     = STAMP_HI_W + STAMP_LO_W;
    localparam int SAMPLES_W   = 32;
    localparam int CNT_W       = 32;
    localparam int BLK_W       = 16;
    localparam int CLASS_W     = 3;
    localparam int NUM_CLASSES = 6;

    localparam int DSP_CNT_W   = 11;
    localparam int DIV_W       = DSP_CNT_W + 1;   // zero count stands for 2^DSP_CNT_W
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    localparam int DIV_BITS_PER_CYCLE = 4;
    localparam int DIV_STEPS          = CHAN_W / DIV_BITS_PER_CYCLE;
    localparam int DIV_CNT_W          = $clog2(DIV_STEPS);

    localparam logic [DSP_CNT_W-1:0] RST_DSP_CNT    = DSP_CNT_W'(128);
    localparam logic [TYPE_W-1:0]    RST_SPIKE_CODE = TYPE_W'(1);
    localparam logic [TYPE_W-1:0]    RST_EVENT_CODE = TYPE_W'(4);
    localparam logic [TYPE_W-1:0]    RST_CONT_CODE  = TYPE_W'(5);

    localparam logic [CLASS_W-1:0] CLS_SPIKE    = CLASS_W'(0);
    localparam logic [CLASS_W-1:0] CLS_EVENT    = CLASS_W'(1);
    localparam logic [CLASS_W-1:0] CLS_WIDEBAND = CLASS_W'(2);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DSP_CNT    = 2'd0,
        CFG_SPIKE_CODE = 2'd1,
        CFG_EVENT_CODE = 2'd2,
        CFG_CONT_CODE  = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        K_SPIKE = 2'd0,
        K_EVENT = 2'd1,
        K_CONT  = 2'd2,
        K_NONE  = 2'd3
    } t_kind;

    typedef struct packed {
        logic [TYPE_W-1:0]     raw_type;
        logic [CHAN_W-1:0]     raw_channel;
        logic [STAMP_HI_W-1:0] stamp_upper;
        logic [STAMP_LO_W-1:0] stamp_lower;
        logic [WORD16_W-1:0]   waveform_count;
        logic [WORD16_W-1:0]   words_per_waveform;
    } t_in_word;

    typedef struct packed {
        logic [CLASS_W-1:0]   block_class;
        logic [CHAN_W-1:0]    channel_out;
        logic [STAMP_W-1:0]   stamp;
        logic [SAMPLES_W-1:0] sample_count;
        logic                 new_frame;
        logic [CNT_W-1:0]     frame_index;
        logic [BLK_W-1:0]     blocks_in_frame;
        logic                 order_error;
        logic [CNT_W-1:0]     total_frames;
    } t_out_word;

    typedef struct packed {
        logic capture;   // take the input word
        logic commit;    // update frame state, load output register
    } t_dp_cmd;

    typedef struct packed {
        logic in_is_cont;  // word on the input is a continuous block
        logic div_busy;
        logic div_last;    // divider does its final step this cycle
    } t_dp_sts;

    function automatic logic [CNT_W-1:0] sat_inc32(input logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + CNT_W'(1);
    endfunction

endpackage

// ----- src/acqf_div.sv -----
// acqf_div: iterative restoring divider, DIV_BITS_PER_CYCLE quotient bits a cycle.
// Depends on acqf_pkg.
module acqf_div
    import acqf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [CHAN_W-1:0] i_dividend,
    input  logic [DIV_W-1:0]  i_divisor,
    output logic              o_busy,
    output logic              o_last,
    output logic [CHAN_W-1:0] o_quotient,
    output logic [DIV_W-1:0]  o_remainder
);

    logic                 r_busy;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0]     r_div;
    logic [DIV_W-1:0]     r_rem, n_rem;
    logic [CHAN_W-1:0]    r_q, n_q;
    logic [DIV_W:0]       trial;

    // q shifts dividend bits out at the top and quotient bits in at the bottom
    always_comb begin
        n_rem = r_rem;
        n_q   = r_q;
        trial = '0;
        for (int k = 0; k < DIV_BITS_PER_CYCLE; k++) begin
            trial = {n_rem, n_q[CHAN_W-1]};
            n_q   = {n_q[CHAN_W-2:0], 1'b0};
            if (trial >= {1'b0, r_div}) begin
                n_rem  = DIV_W'(trial - {1'b0, r_div});
                n_q[0] = 1'b1;
            end else begin
                n_rem = DIV_W'(trial);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + DIV_CNT_W'(1);
            if (o_last) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div <= i_divisor;
            r_rem <= '0;
            r_q   <= i_dividend;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_q   <= n_q;
        end
    end

    assign o_busy      = r_busy;
    assign o_last      = r_busy && (r_cnt == DIV_CNT_W'(DIV_STEPS - 1));
    assign o_quotient  = r_q;
    assign o_remainder = r_rem;

endmodule

// ----- src/acqf_dp.sv -----
// acqf_dp: datapath - config registers, input capture, divider, frame state, output register.
// Depends on acqf_pkg and acqf_div.
module acqf_dp
    import acqf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_in_word              i_in,
    input  t_dp_cmd               i_cmd,
    output t_dp_sts               o_sts,
    output t_out_word             o_out
);

    // configuration
    logic [DSP_CNT_W-1:0] r_dsp_cnt;
    logic [TYPE_W-1:0]    r_spike_code, r_event_code, r_cont_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dsp_cnt    <= RST_DSP_CNT;
            r_spike_code <= RST_SPIKE_CODE;
            r_event_code <= RST_EVENT_CODE;
            r_cont_code  <= RST_CONT_CODE;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_DSP_CNT:    r_dsp_cnt    <= i_cfg_data[DSP_CNT_W-1:0];
                CFG_SPIKE_CODE: r_spike_code <= i_cfg_data[TYPE_W-1:0];
                CFG_EVENT_CODE: r_event_code <= i_cfg_data[TYPE_W-1:0];
                CFG_CONT_CODE:  r_cont_code  <= i_cfg_data[TYPE_W-1:0];
                default: ;
            endcase
        end
    end

    // classify straight off the input; first match wins
    t_kind in_kind;
    always_comb begin
        if (i_in.raw_type == r_spike_code) begin
            in_kind = K_SPIKE;
        end else if (i_in.raw_type == r_event_code) begin
            in_kind = K_EVENT;
        end else if (i_in.raw_type == r_cont_code) begin
            in_kind = K_CONT;
        end else begin
            in_kind = K_NONE;
        end
    end

    // captured word
    t_kind                r_kind;
    logic [CHAN_W-1:0]    r_chan;
    logic [STAMP_W-1:0]   r_stamp;
    logic [SAMPLES_W-1:0] r_samples;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind    <= in_kind;
            r_chan    <= i_in.raw_channel;
            r_stamp   <= {i_in.stamp_upper, i_in.stamp_lower};
            r_samples <= {{(SAMPLES_W-WORD16_W){1'b0}}, i_in.waveform_count}
                       * {{(SAMPLES_W-WORD16_W){1'b0}}, i_in.words_per_waveform};
        end
    end

    // channel / count: count of zero means the full 2^DSP_CNT_W
    logic              div_start, div_busy, div_last;
    logic [DIV_W-1:0]  divisor, div_rem;
    logic [CHAN_W-1:0] div_quo;

    assign div_start = i_cmd.capture && (in_kind == K_CONT);
    assign divisor   = {(r_dsp_cnt == '0), r_dsp_cnt};

    acqf_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (i_in.raw_channel),
        .i_divisor   (divisor),
        .o_busy      (div_busy),
        .o_last      (div_last),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    assign o_sts.in_is_cont = (in_kind == K_CONT);
    assign o_sts.div_busy   = div_busy;
    assign o_sts.div_last   = div_last;

    // frame state
    logic [STAMP_W-1:0]  r_frame_stamp;
    logic [WORD16_W-1:0] r_frame_samples;
    logic [CLASS_W-1:0]  r_frame_class;
    logic [CLASS_W-1:0]  r_prev_class;
    logic [CHAN_W-1:0]   r_last_chan;
    logic [BLK_W-1:0]    r_blk_cnt, n_blk_cnt;
    logic [CNT_W-1:0]    r_fpc [NUM_CLASSES];
    logic [CNT_W-1:0]    r_total, n_total;
    logic                r_frame_open;

    logic [CLASS_W-1:0]  cls;
    logic [CHAN_W-1:0]   chan_o;
    logic                is_new;
    logic [CNT_W-1:0]    fpc_cur, n_fpc;
    logic [CHAN_W-1:0]   last_eff;
    logic                order_err;

    always_comb begin
        cls    = r_prev_class;
        chan_o = r_chan;
        case (r_kind)
            K_SPIKE: cls = CLS_SPIKE;
            K_EVENT: cls = CLS_EVENT;
            K_CONT: begin
                chan_o = CHAN_W'(div_rem) + CHAN_W'(1);
                if (div_quo[CHAN_W-1:2] == '0) begin
                    cls = CLS_WIDEBAND + CLASS_W'(div_quo[1:0]);
                end
            end
            default: ;
        endcase

        is_new = !r_frame_open || (r_stamp != r_frame_stamp) || (cls != r_frame_class)
              || (r_samples[WORD16_W-1:0] != r_frame_samples);

        // a block that does not open a frame has the frame's class, so cls indexes both
        fpc_cur   = r_fpc[cls];
        n_fpc     = is_new ? sat_inc32(fpc_cur) : fpc_cur;
        n_total   = is_new ? sat_inc32(r_total) : r_total;
        if (is_new) begin
            n_blk_cnt = BLK_W'(1);
        end else if (r_blk_cnt != '1) begin
            n_blk_cnt = r_blk_cnt + BLK_W'(1);
        end else begin
            n_blk_cnt = r_blk_cnt;
        end

        last_eff  = is_new ? '0 : r_last_chan;
        order_err = (cls >= CLS_WIDEBAND)
                 && (({1'b0, last_eff} + (CHAN_W+1)'(1)) != {1'b0, chan_o});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_stamp   <= '0;
            r_frame_samples <= '0;
            r_frame_class   <= CLS_SPIKE;
            r_prev_class    <= CLS_SPIKE;
            r_last_chan     <= '0;
            r_blk_cnt       <= '0;
            r_total         <= '0;
            r_frame_open    <= 1'b0;
            for (int c = 0; c < NUM_CLASSES; c++) begin
                r_fpc[c] <= '0;
            end
        end else if (i_cmd.commit) begin
            r_prev_class <= cls;
            r_last_chan  <= chan_o;
            r_blk_cnt    <= n_blk_cnt;
            r_total      <= n_total;
            r_fpc[cls]   <= n_fpc;
            if (is_new) begin
                r_frame_open    <= 1'b1;
                r_frame_stamp   <= r_stamp;
                r_frame_samples <= r_samples[WORD16_W-1:0];
                r_frame_class   <= cls;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            o_out.block_class     <= cls;
            o_out.channel_out     <= chan_o;
            o_out.stamp           <= r_stamp;
            o_out.sample_count    <= r_samples;
            o_out.new_frame       <= is_new;
            o_out.frame_index     <= n_fpc - CNT_W'(1);
            o_out.blocks_in_frame <= n_blk_cnt;
            o_out.order_error     <= order_err;
            o_out.total_frames    <= n_total;
        end
    end

endmodule

// ----- src/acqf_ctrl.sv -----
// acqf_ctrl: controller FSM and channel handshakes for the block header framer.
// Depends on acqf_pkg.
module acqf_ctrl
    import acqf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_UPD  = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid;
    logic   accept, out_free;

    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state       = r_state;
        o_cmd.capture = 1'b0;
        o_cmd.commit  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = i_sts.in_is_cont ? S_DIV : S_UPD;
                end
            end
            S_DIV: begin
                if (i_sts.div_last) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                if (out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

`ifndef NO_ASSERTIONS
    a_div_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> i_sts.div_busy)
        else $error("controller waits on an idle divider");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> out_free)
        else $error("output word overwritten before it was taken");

    a_short_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !i_sts.in_is_cont) |=> (r_state == S_UPD))
        else $error("non-continuous word did not go straight to update");

    a_commit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> o_out_valid)
        else $error("committed word not presented");
`endif

endmodule

// ----- src/acq_block_header_framer_core.sv -----
// acq_block_header_framer_core: top level, one result word per header word.
// Flow: spike, event and unknown types go from accept via the update state to output valid;
//   continuous blocks pass through the divider first, 4 quotient bits per divider cycle.
// A new header is taken only once the last one is committed; a held output adds waits.
// Reset: synchronous active-low i_rst_n clears config to defaults and all frame state.
// Depends on acqf_pkg, acqf_ctrl, acqf_dp.
module acq_block_header_framer_core
    import acqf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // header word in
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_word              i_in,
    // result word out
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_word             o_out
);

    // Controller sequences capture -> (divide) -> update; datapath holds
    // everything else, including the output register so the next header
    // can be taken while a result waits downstream.
    t_dp_cmd cmd;
    t_dp_sts sts;

    acqf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Datapath: channel remap by the divider, frame boundary detection,
    // saturating per-class and total frame counters, order check.
    acqf_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_out      (o_out)
    );

endmodule
